### design/fqs_pkg.sv
// ----------------------------------------------------------------------------
// fqs_pkg: shared constants and types for the searchable FIFO queue
// Queue depth, field widths, request codes and the per-cell command word.
// ----------------------------------------------------------------------------
package fqs_pkg;

    localparam int DEPTH    = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(DEPTH);
    localparam int CNT_W    = $clog2(DEPTH + 1);
    localparam int POS_W    = 4;
    localparam int REQ_W    = 2;
    localparam int OUT_W    = 16;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH   = 2'd0,
        REQ_POP    = 2'd1,
        REQ_SEARCH = 2'd2,
        REQ_NONE   = 2'd3
    } req_t;

    // Command broadcast to every cell in the row
    typedef struct packed {
        logic push;
        logic pop;
    } cell_cmd_t;

endpackage

### design/fqs_cell.sv
// ----------------------------------------------------------------------------
// fqs_cell: one slot of the queue row
// Holds one word and an occupied flag; loads on push at the tail boundary,
// takes its upper neighbour's contents on pop, and compares against the key.
// ----------------------------------------------------------------------------
module fqs_cell (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  fqs_pkg::cell_cmd_t        cmd,
    input  logic [fqs_pkg::DATA_W-1:0] value,
    input  logic                      prev_occ,
    input  logic [fqs_pkg::DATA_W-1:0] next_data,
    input  logic                      next_occ,
    output logic [fqs_pkg::DATA_W-1:0] data,
    output logic                      occ,
    output logic                      match
);

    logic [fqs_pkg::DATA_W-1:0] data_reg, data_next;
    logic                       occ_reg, occ_next;

    always_comb begin
        data_next = data_reg;
        occ_next  = occ_reg;
        if (cmd.pop) begin
            data_next = next_data;
            occ_next  = next_occ;
        end else if (cmd.push && !occ_reg && prev_occ) begin
            // first free slot takes the pushed word
            data_next = value;
            occ_next  = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= 1'b0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data  = data_reg;
    assign occ   = occ_reg;
    assign match = occ_reg && (data_reg == value);

endmodule

### design/fqs_prio.sv
// ----------------------------------------------------------------------------
// fqs_prio: first-match priority encoder
// Gives the lowest cell index with a match, i.e. the match nearest the head.
// ----------------------------------------------------------------------------
module fqs_prio (
    input  logic [fqs_pkg::DEPTH-1:0] match_vec,
    output logic                      found,
    output logic [fqs_pkg::IDX_W-1:0] position
);

    always_comb begin
        found    = 1'b0;
        position = '0;
        for (int k = fqs_pkg::DEPTH - 1; k >= 0; k--) begin
            if (match_vec[k]) begin
                found    = 1'b1;
                position = fqs_pkg::IDX_W'(k);
            end
        end
    end

endmodule

### design/fifo_queue_with_search.sv
// ----------------------------------------------------------------------------
// fifo_queue_with_search: bounded FIFO queue with associative search
// Row of cells, cell 0 at the head. Push fills the first free cell, pop
// shifts the row one cell towards the head, search compares all cells.
// ----------------------------------------------------------------------------
//  channel | dir | ports                        | word
//  s_      | in  | s_tvalid s_tready s_tdata    | request: tuser kind, tdata value
//          |     | s_tuser                      |
//  m_      | out | m_tvalid m_tready m_tdata    | one status word per request
//
//  One request per cycle while the output is not stalled; each passes through
//  the cell row into the output register, so the result appears the cycle after acceptance.
//  Search is a parallel compare in every cell plus a 16-way priority encode.
//  A stalled output holds its word; s_tready drops only while it is stalled.
//  Synchronous active-low reset empties the queue (occupied flags cleared).
// ----------------------------------------------------------------------------
module fifo_queue_with_search (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] req_type
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] accepted, [1] found, [5:2] position, [10:6] occupancy,
    // [11] is_empty, [12] is_full, [15:13] zero
    output logic [15:0] m_tdata
);

    localparam int D = fqs_pkg::DEPTH;

    logic                       s_accept;
    fqs_pkg::req_t              req;
    fqs_pkg::cell_cmd_t         cmd;
    logic [fqs_pkg::DATA_W-1:0] value;

    logic [fqs_pkg::DATA_W-1:0] data_vec [D];
    logic [D-1:0]               occ_vec;
    logic [D-1:0]               match_vec;

    logic                       full, empty;
    logic                       srch_found;
    logic [fqs_pkg::IDX_W-1:0]  srch_pos;

    logic [fqs_pkg::CNT_W-1:0]  count_reg, count_next;
    logic                       out_valid_reg;
    logic [fqs_pkg::OUT_W-1:0]  out_word_reg, out_word_next;

    logic                       res_accepted, res_found;
    logic [fqs_pkg::POS_W-1:0]  res_pos;

    assign s_tready = !out_valid_reg || m_tready;
    assign s_accept = s_tvalid && s_tready;
    assign req      = fqs_pkg::req_t'(s_tuser);
    assign value    = s_tdata[fqs_pkg::DATA_W-1:0];

    assign full  = occ_vec[D-1];
    assign empty = !occ_vec[0];

    // only a request that changes the queue drives the row
    assign cmd.push = s_accept && (req == fqs_pkg::REQ_PUSH) && !full;
    assign cmd.pop  = s_accept && (req == fqs_pkg::REQ_POP) && !empty;

    for (genvar k = 0; k < D; k++) begin : g_cell
        logic                       prev_occ;
        logic [fqs_pkg::DATA_W-1:0] next_data;
        logic                       next_occ;

        if (k == 0) begin : g_head
            assign prev_occ = 1'b1;
        end else begin : g_mid
            assign prev_occ = occ_vec[k-1];
        end

        if (k == D - 1) begin : g_last
            assign next_data = '0;
            assign next_occ  = 1'b0;
        end else begin : g_inner
            assign next_data = data_vec[k+1];
            assign next_occ  = occ_vec[k+1];
        end

        fqs_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .value     (value),
            .prev_occ  (prev_occ),
            .next_data (next_data),
            .next_occ  (next_occ),
            .data      (data_vec[k]),
            .occ       (occ_vec[k]),
            .match     (match_vec[k])
        );
    end

    fqs_prio u_prio (
        .match_vec (match_vec),
        .found     (srch_found),
        .position  (srch_pos)
    );

    // result word for the request being accepted
    always_comb begin
        count_next = count_reg;
        if (cmd.push) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.pop) begin
            count_next = count_reg - 1'b1;
        end

        res_accepted = cmd.push || cmd.pop;
        res_found    = 1'b0;
        res_pos      = '0;
        if (req == fqs_pkg::REQ_SEARCH) begin
            res_found = srch_found;
            res_pos   = fqs_pkg::POS_W'(srch_pos);
        end

        out_word_next = {3'b000,
                         (count_next == fqs_pkg::CNT_W'(D)),
                         (count_next == '0),
                         count_next,
                         res_pos,
                         res_found,
                         res_accepted};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            count_reg <= count_next;
            if (s_accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            out_word_reg <= out_word_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg;

    // occupied flags and the count must agree
    a_count_occ : assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(occ_vec) == 32'(count_reg))
        else $error("count does not match occupied cells");

    // occupied cells form a contiguous run from the head (all-ones from bit 0)
    a_contig : assert property (@(posedge aclk) disable iff (!aresetn)
        ((occ_vec + {{(D-1){1'b0}}, 1'b1}) & occ_vec) == '0)
        else $error("occupied cells not contiguous from head");

    // a pop on a non-empty queue removes exactly one word
    a_pop_dec : assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pop |=> count_reg == $past(count_reg) - 1'b1)
        else $error("pop did not decrement count");

    // a match is only ever reported for a search, which never changes the queue
    a_found_search : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[1]) |-> !m_tdata[0])
        else $error("found reported with queue change");

endmodule
